// File: design/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg : shared definitions for the length framed packet deframer
// Field kind codes for the result beat, register offsets and widths.
// ----------------------------------------------------------------------------
package lfpd_pkg;

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 3;
   localparam int INDEX_W = 6;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [INDEX_W-1:0] index_type;

   localparam kind_type KIND_DISCARD  = 3'd0;
   localparam kind_type KIND_START    = 3'd1;
   localparam kind_type KIND_VERSION  = 3'd2;
   localparam kind_type KIND_COMMAND  = 3'd3;
   localparam kind_type KIND_LENGTH   = 3'd4;
   localparam kind_type KIND_PAYLOAD  = 3'd5;
   localparam kind_type KIND_FEEDBACK = 3'd6;

   localparam logic [0:0] REG_START_MARKER = 1'd0;
   localparam byte_type   START_MARKER_RST = 8'h7e;

endpackage

// File: design/length_framed_packet_deframer.sv
// ----------------------------------------------------------------------------
// length_framed_packet_deframer : byte stream frame parser
// Hunts for the start byte, tags version, command, length, payload and
// feedback bytes, and flags a length above the payload capacity.
// ----------------------------------------------------------------------------
//  channel  | direction | ports                       | beat
//  ---------+-----------+-----------------------------+-------------------------
//  req      | in        | req_valid/ready, rx_byte    | one received byte
//  rsp      | out       | rsp_valid/ready, fields     | one tagged byte
//  csr      | in/out    | APB psel..pready            | start marker register
//
//  One byte per cycle when no result stalls; a result appears in the cycle
//  after its byte is taken, from the single output register fed by the
//  phase decode. Reset brings the phase to hunting, clears the counters and
//  empties the output register. A stalled result holds its register and
//  still lets the next byte in once the result is taken in that same cycle.
// ----------------------------------------------------------------------------
module length_framed_packet_deframer #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_field_kind,
   output logic [7:0]                  rsp_field_value,
   output logic [5:0]                  rsp_payload_index,
   output logic                        rsp_frame_done,
   output logic                        rsp_length_error,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [lfpd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [lfpd_pkg::DATA_W-1:0] csr_pwdata,
   output logic [lfpd_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

   localparam logic [2:0] PH_HUNT     = 3'd0;
   localparam logic [2:0] PH_VERSION  = 3'd1;
   localparam logic [2:0] PH_COMMAND  = 3'd2;
   localparam logic [2:0] PH_LENGTH   = 3'd3;
   localparam logic [2:0] PH_PAYLOAD  = 3'd4;
   localparam logic [2:0] PH_FEEDBACK = 3'd5;

   lfpd_pkg::byte_type   start_marker;

   logic [2:0]           phase_ff, phase_in;
   logic [CNT_W-1:0]     count_ff, count_in, count_inc;
   logic [CNT_W-1:0]     length_ff, length_in;
   logic [7:0]           count_wide;

   logic                 rsp_valid_ff, rsp_valid_in;
   lfpd_pkg::kind_type   kind_ff, kind_in;
   lfpd_pkg::byte_type   value_ff;
   lfpd_pkg::index_type  index_ff, index_in;
   logic                 done_ff, done_in;
   logic                 error_ff, error_in;
   logic                 accept;

   lfpd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .start_marker (start_marker)
   );

   assign req_ready  = ~rsp_valid_ff | rsp_ready;
   assign accept     = req_valid & req_ready;
   assign count_inc  = CNT_W'(count_ff + 1'b1);
   assign count_wide = 8'(count_ff);

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      length_in = length_ff;
      kind_in   = lfpd_pkg::KIND_DISCARD;
      index_in  = '0;
      done_in   = 1'b0;
      error_in  = 1'b0;
      case (phase_ff)
         PH_VERSION: begin
            kind_in  = lfpd_pkg::KIND_VERSION;
            phase_in = PH_COMMAND;
         end
         PH_COMMAND: begin
            kind_in  = lfpd_pkg::KIND_COMMAND;
            phase_in = PH_LENGTH;
         end
         PH_LENGTH: begin
            kind_in = lfpd_pkg::KIND_LENGTH;
            if (32'(req_rx_byte) > MAX_PAYLOAD) begin
               error_in = 1'b1;
               phase_in = PH_HUNT;
            end else begin
               length_in = CNT_W'(req_rx_byte);
               count_in  = '0;
               phase_in  = (req_rx_byte == 8'd0) ? PH_FEEDBACK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            kind_in  = lfpd_pkg::KIND_PAYLOAD;
            index_in = count_wide[lfpd_pkg::INDEX_W-1:0];
            count_in = count_inc;
            if (count_inc >= length_ff) begin
               phase_in = PH_FEEDBACK;
            end
         end
         PH_FEEDBACK: begin
            kind_in  = lfpd_pkg::KIND_FEEDBACK;
            done_in  = 1'b1;
            phase_in = PH_HUNT;
         end
         default: begin
            if (req_rx_byte == start_marker) begin
               kind_in  = lfpd_pkg::KIND_START;
               phase_in = PH_VERSION;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   assign rsp_valid_in = req_ready ? req_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         count_ff     <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            length_ff <= length_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= kind_in;
         value_ff <= req_rx_byte;
         index_ff <= index_in;
         done_ff  <= done_in;
         error_ff <= error_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_field_kind    = kind_ff;
   assign rsp_field_value   = value_ff;
   assign rsp_payload_index = index_ff;
   assign rsp_frame_done    = done_ff;
   assign rsp_length_error  = error_ff;

endmodule

// File: design/lfpd_csr.sv
// ----------------------------------------------------------------------------
// lfpd_csr : configuration register block
// APB-style slave holding the start marker byte; always ready, reads back.
// ----------------------------------------------------------------------------
module lfpd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [lfpd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [lfpd_pkg::DATA_W-1:0] csr_pwdata,
   output logic [lfpd_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output lfpd_pkg::byte_type          start_marker
);

   lfpd_pkg::byte_type start_marker_ff;
   lfpd_pkg::byte_type start_marker_in;
   logic               reg_hit;
   logic               wr_en;

   assign reg_hit = (csr_paddr[lfpd_pkg::ADDR_W-1 -: 1] == lfpd_pkg::REG_START_MARKER);
   assign wr_en   = csr_psel & csr_penable & csr_pwrite & reg_hit;

   always_comb begin
      start_marker_in = start_marker_ff;
      if (wr_en) begin
         start_marker_in = csr_pwdata[lfpd_pkg::BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= lfpd_pkg::START_MARKER_RST;
      end else begin
         start_marker_ff <= start_marker_in;
      end
   end

   assign csr_pready   = 1'b1;
   assign csr_prdata   = reg_hit ? lfpd_pkg::DATA_W'(start_marker_ff) : '0;
   assign start_marker = start_marker_ff;

endmodule

// File: design/lfpd_checker.sv
// ----------------------------------------------------------------------------
// lfpd_checker : port level checks for the deframer
// Result tag consistency, back pressure and stall behaviour, bound to the top.
// ----------------------------------------------------------------------------
module lfpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_field_kind,
   input logic [7:0] rsp_field_value,
   input logic [5:0] rsp_payload_index,
   input logic       rsp_frame_done,
   input logic       rsp_length_error
);

   a_done_on_feedback : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_field_kind == lfpd_pkg::KIND_FEEDBACK)
      else $error("frame_done on a beat that is not feedback");

   a_error_on_length : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_error |-> rsp_field_kind == lfpd_pkg::KIND_LENGTH)
      else $error("length_error on a beat that is not length");

   a_index_on_payload : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_index != 6'd0 |->
         rsp_field_kind == lfpd_pkg::KIND_PAYLOAD)
      else $error("payload_index set on a beat that is not payload");

   a_backpressure : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a stalled result");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_field_kind)
         && $stable(rsp_field_value))
      else $error("stalled result beat changed");

endmodule

bind length_framed_packet_deframer lfpd_checker u_lfpd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_field_kind    (rsp_field_kind),
   .rsp_field_value   (rsp_field_value),
   .rsp_payload_index (rsp_payload_index),
   .rsp_frame_done    (rsp_frame_done),
   .rsp_length_error  (rsp_length_error)
);

// File: test/length_framed_packet_deframer_test.sv
// ----------------------------------------------------------------------------
// length_framed_packet_deframer_test : self-checking bench for the deframer
// Feeds a byte stream through the request channel: a table of directed
// bytes, then random frames, noise and broken headers. The random part runs
// under several start markers and several sender and receiver idling mixes.
// Each byte is tagged from the table or by a local phase tracker, and every
// result beat is compared field by field with the oldest outstanding tag.
// ----------------------------------------------------------------------------
module length_framed_packet_deframer_test;

   localparam int FRAME_CAPACITY = 64;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEMS_PER_PHASE = 125;
   localparam logic [lfpd_pkg::ADDR_W-1:0] MARKER_ADDR = {lfpd_pkg::REG_START_MARKER, 2'b00};
   localparam logic [lfpd_pkg::ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

   typedef enum logic [2:0] {
      PH_HUNT, PH_VERSION, PH_COMMAND, PH_LENGTH, PH_PAYLOAD, PH_FEEDBACK
   } frame_phase_type;

   typedef struct packed {
      lfpd_pkg::kind_type  kind;
      lfpd_pkg::byte_type  value;
      lfpd_pkg::index_type index;
      logic                done;
      logic                err;
   } byte_tag_type;

   typedef struct {
      lfpd_pkg::byte_type  rx;
      bit                  typed;
      lfpd_pkg::kind_type  kind;
      lfpd_pkg::index_type index;
      logic                done;
      logic                err;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [7:0]                    req_rx_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [2:0]                    rsp_field_kind;
   logic [7:0]                    rsp_field_value;
   logic [5:0]                    rsp_payload_index;
   logic                          rsp_frame_done;
   logic                          rsp_length_error;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [lfpd_pkg::ADDR_W-1:0]   csr_paddr = '0;
   logic [lfpd_pkg::DATA_W-1:0]   csr_pwdata = '0;
   logic [lfpd_pkg::DATA_W-1:0]   csr_prdata;
   logic                          csr_pready;

   frame_phase_type     frame_phase = PH_HUNT;
   logic [7:0]          payload_seen = '0;
   logic [7:0]          frame_len = '0;
   lfpd_pkg::byte_type  start_byte = lfpd_pkg::START_MARKER_RST;

   byte_tag_type        pending_tags[$];
   byte_tag_type        oldest_tag;
   int                  failures = 0;
   int                  items_sent = 0;
   int                  quiet_cycles = 0;
   int unsigned         req_idle_pct = 0;
   int unsigned         rsp_stall_pct = 0;
   int                  hold_cycles = 0;

   stim_row_type directed_rows[23] = '{
      '{8'h00, 1'b1, lfpd_pkg::KIND_DISCARD,  6'd0, 1'b0, 1'b0},
      '{8'hFF, 1'b1, lfpd_pkg::KIND_DISCARD,  6'd0, 1'b0, 1'b0},
      '{8'h55, 1'b1, lfpd_pkg::KIND_DISCARD,  6'd0, 1'b0, 1'b0},
      '{8'h7E, 1'b1, lfpd_pkg::KIND_START,    6'd0, 1'b0, 1'b0},
      '{8'h01, 1'b1, lfpd_pkg::KIND_VERSION,  6'd0, 1'b0, 1'b0},
      '{8'h7E, 1'b1, lfpd_pkg::KIND_COMMAND,  6'd0, 1'b0, 1'b0},
      '{8'h00, 1'b1, lfpd_pkg::KIND_LENGTH,   6'd0, 1'b0, 1'b0},
      '{8'hA5, 1'b1, lfpd_pkg::KIND_FEEDBACK, 6'd0, 1'b1, 1'b0},
      '{8'h7E, 1'b1, lfpd_pkg::KIND_START,    6'd0, 1'b0, 1'b0},
      '{8'hFF, 1'b1, lfpd_pkg::KIND_VERSION,  6'd0, 1'b0, 1'b0},
      '{8'h00, 1'b1, lfpd_pkg::KIND_COMMAND,  6'd0, 1'b0, 1'b0},
      '{8'h41, 1'b1, lfpd_pkg::KIND_LENGTH,   6'd0, 1'b0, 1'b1},
      '{8'h03, 1'b1, lfpd_pkg::KIND_DISCARD,  6'd0, 1'b0, 1'b0},
      '{8'h7E, 1'b1, lfpd_pkg::KIND_START,    6'd0, 1'b0, 1'b0},
      '{8'h02, 1'b1, lfpd_pkg::KIND_VERSION,  6'd0, 1'b0, 1'b0},
      '{8'h05, 1'b1, lfpd_pkg::KIND_COMMAND,  6'd0, 1'b0, 1'b0},
      '{8'hFF, 1'b1, lfpd_pkg::KIND_LENGTH,   6'd0, 1'b0, 1'b1},
      '{8'h7E, 1'b1, lfpd_pkg::KIND_START,    6'd0, 1'b0, 1'b0},
      '{8'h80, 1'b1, lfpd_pkg::KIND_VERSION,  6'd0, 1'b0, 1'b0},
      '{8'h7F, 1'b1, lfpd_pkg::KIND_COMMAND,  6'd0, 1'b0, 1'b0},
      '{8'h02, 1'b1, lfpd_pkg::KIND_LENGTH,   6'd0, 1'b0, 1'b0},
      '{8'h7E, 1'b0, lfpd_pkg::KIND_DISCARD,  6'd0, 1'b0, 1'b0},
      '{8'hFF, 1'b0, lfpd_pkg::KIND_DISCARD,  6'd0, 1'b0, 1'b0}
   };

   length_framed_packet_deframer #(
      .MAX_PAYLOAD(FRAME_CAPACITY)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_field_kind    (rsp_field_kind),
      .rsp_field_value   (rsp_field_value),
      .rsp_payload_index (rsp_payload_index),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_length_error  (rsp_length_error),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic byte_tag_type tag_byte(input lfpd_pkg::byte_type b);
      byte_tag_type t;
      t = '{kind: lfpd_pkg::KIND_DISCARD, value: b, index: '0, done: 1'b0, err: 1'b0};
      case (frame_phase)
         PH_VERSION: begin
            t.kind = lfpd_pkg::KIND_VERSION;
            frame_phase = PH_COMMAND;
         end
         PH_COMMAND: begin
            t.kind = lfpd_pkg::KIND_COMMAND;
            frame_phase = PH_LENGTH;
         end
         PH_LENGTH: begin
            t.kind = lfpd_pkg::KIND_LENGTH;
            if (b > FRAME_CAPACITY) begin
               t.err = 1'b1;
               frame_phase = PH_HUNT;
            end else begin
               frame_len = b;
               payload_seen = '0;
               if (b == 8'd0) frame_phase = PH_FEEDBACK;
               else frame_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            t.kind = lfpd_pkg::KIND_PAYLOAD;
            t.index = payload_seen[lfpd_pkg::INDEX_W-1:0];
            payload_seen = payload_seen + 8'd1;
            if (payload_seen >= frame_len) frame_phase = PH_FEEDBACK;
         end
         PH_FEEDBACK: begin
            t.kind = lfpd_pkg::KIND_FEEDBACK;
            t.done = 1'b1;
            frame_phase = PH_HUNT;
         end
         default: begin
            if (b == start_byte) begin
               t.kind = lfpd_pkg::KIND_START;
               frame_phase = PH_VERSION;
            end
         end
      endcase
      return t;
   endfunction

   task automatic send_byte(input lfpd_pkg::byte_type b, input bit use_given = 1'b0,
                            input byte_tag_type given = '0);
      byte_tag_type computed;
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      computed = tag_byte(b);
      pending_tags.push_back(use_given ? given : computed);
      items_sent++;
   endtask

   function automatic lfpd_pkg::byte_type random_byte();
      if ($urandom_range(7) == 0) return start_byte;
      return lfpd_pkg::byte_type'($urandom_range(255));
   endfunction

   task automatic send_frame(input int len);
      send_byte(start_byte);
      send_byte(random_byte());
      send_byte(random_byte());
      send_byte(lfpd_pkg::byte_type'(len));
      if (len <= FRAME_CAPACITY) begin
         repeat (len) send_byte(random_byte());
         send_byte(random_byte());
      end
   endtask

   function automatic int pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55) return $urandom_range(0, 4);
      if (r < 75) return $urandom_range(5, FRAME_CAPACITY - 1);
      if (r < 80) return FRAME_CAPACITY;
      if (r < 90) return FRAME_CAPACITY + 1;
      return $urandom_range(FRAME_CAPACITY + 1, 255);
   endfunction

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_tags.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [lfpd_pkg::ADDR_W-1:0] addr,
                            input logic [lfpd_pkg::DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr[lfpd_pkg::ADDR_W-1:2] == lfpd_pkg::REG_START_MARKER)
         start_byte = data[lfpd_pkg::BYTE_W-1:0];
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_tags.size() == 0) begin
            $error("unexpected result beat: kind %0d value %0h", rsp_field_kind,
                   rsp_field_value);
            failures++;
         end else begin
            oldest_tag = pending_tags.pop_front();
            check_field("field_kind", 8'(oldest_tag.kind), 8'(rsp_field_kind));
            check_field("field_value", oldest_tag.value, rsp_field_value);
            check_field("payload_index", 8'(oldest_tag.index), 8'(rsp_payload_index));
            check_field("frame_done", 8'(oldest_tag.done), 8'(rsp_frame_done));
            check_field("length_error", 8'(oldest_tag.err), 8'(rsp_length_error));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
      begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      int unsigned idle_pcts[4];
      int unsigned stall_pcts[4];
      lfpd_pkg::byte_type markers[4];
      int sel;
      int target;
      idle_pcts = '{0, 80, 0, 12};
      stall_pcts = '{0, 0, 80, 12};
      markers = '{8'h00, 8'hFF, lfpd_pkg::byte_type'($urandom_range(1, 254)),
                  lfpd_pkg::START_MARKER_RST};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // an unmapped register must leave the marker alone
      write_csr(UNMAPPED_ADDR, 32'h0000_0055);
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].rx, directed_rows[i].typed,
                   '{directed_rows[i].kind, directed_rows[i].rx, directed_rows[i].index,
                     directed_rows[i].done, directed_rows[i].err});
      end
      send_byte(8'h00);
      send_frame(FRAME_CAPACITY);
      send_frame(1);

      for (int p = 0; p < 4; p++) begin
         wait_idle();
         write_csr(MARKER_ADDR, {24'($urandom_range(32'hFFFFFF)), markers[p]});
         req_idle_pct = idle_pcts[p];
         rsp_stall_pct = stall_pcts[p];
         if (p == 0) hold_cycles = HOLD_OFF_CYCLES;
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
               send_frame(pick_length());
            end else if (sel < 85) begin
               repeat ($urandom_range(1, 6)) send_byte(random_byte());
            end else begin
               send_byte(start_byte);
               repeat (3) send_byte(lfpd_pkg::byte_type'($urandom_range(255)));
            end
         end
      end

      rsp_stall_pct = 0;
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_tags.size() != 0) begin
         $error("%0d result beats never arrived", pending_tags.size());
         failures++;
      end
      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

// File: files.f
design/lfpd_pkg.sv
design/lfpd_csr.sv
design/length_framed_packet_deframer.sv
design/lfpd_checker.sv
test/length_framed_packet_deframer_test.sv
